@@ sv/hse_pkg.sv @@
// shared types, codes and constants of the hash set engine
`default_nettype none

package hse_pkg;

  localparam int KEY_W            = 32;
  localparam int OP_W             = 2;
  localparam int COUNT_W          = 10;
  localparam int CFG_W            = 7;
  localparam int DIV_CNT_W        = $clog2(KEY_W);
  localparam int APB_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;
  localparam int REG_IDX_W        = APB_ADDR_W - 2;

  localparam int NUM_BUCKETS_DEF  = 64;
  localparam int BUCKET_DEPTH_DEF = 8;

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 7'd64;

  localparam logic [REG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b0;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_CONTAINS = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

  typedef struct packed {
    logic load;
    logic div_step;
    logic hash;
    logic scan_init;
    logic scan;
    logic wipe;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic scan_last;
    logic wipe_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/hse_ctrl.sv @@
// sequencing state machine of the hash set engine
`default_nettype none

module hse_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hse_pkg::OP_W-1:0]    operation,
  input  hse_pkg::dp_stat_t           stat,
  output hse_pkg::dp_cmd_t            cmd,
  output logic                        busy
);
  import hse_pkg::*;

  typedef enum logic [7:0] {
    S_WIPE   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DIV    = 8'b0000_0100,
    S_HASH   = 8'b0000_1000,
    S_ROW    = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_CLEAR  = 8'b0100_0000,
    S_COMMIT = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_WIPE: begin
        cmd.wipe = 1'b1;
        if (stat.wipe_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (operation == OP_CLEAR) ? S_CLEAR : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_HASH;
      end
      S_HASH: begin
        cmd.hash   = 1'b1;
        state_next = S_ROW;
      end
      S_ROW: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_next = S_COMMIT;
      end
      S_CLEAR: begin
        cmd.wipe = 1'b1;
        if (stat.wipe_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_WIPE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

@@ sv/hse_datapath.sv @@
// modulo unit, slot memories, bucket scan and result registers
`default_nettype none

module hse_datapath #(
  parameter int NUM_BUCKETS  = hse_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = hse_pkg::BUCKET_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hse_pkg::dp_cmd_t                  cmd,
  output hse_pkg::dp_stat_t                 stat,
  input  logic [hse_pkg::OP_W-1:0]          operation,
  input  logic signed [hse_pkg::KEY_W-1:0]  key_value,
  input  logic [hse_pkg::CFG_W-1:0]         bucket_count,
  output logic                              done,
  output logic                              was_present,
  output logic                              status,
  output logic [hse_pkg::COUNT_W-1:0]       element_count
);
  import hse_pkg::*;

  localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int IW    = $clog2(BUCKET_DEPTH + 1);
  localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW    = (BW > CFG_W) ? BW : CFG_W;
  localparam int CFG_MAX = (2 ** CFG_W) - 1;
  localparam logic [CFG_W-1:0] NB_CAP =
    (NUM_BUCKETS > CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(NUM_BUCKETS);

  logic [BUCKET_DEPTH-1:0] valid_mem [NUM_BUCKETS];
  logic [KEY_W-1:0]        slot_mem  [SLOTS];

  logic [OP_W-1:0]      op_q;
  logic [KEY_W-1:0]     key_q;
  logic                 neg_q;
  logic [KEY_W-1:0]     dvd_q;
  logic [CFG_W-1:0]     div_q;
  logic [CFG_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  logic [KEY_W-1:0]     key_bits;
  logic [KEY_W-1:0]     key_abs;
  logic [CFG_W-1:0]     eff_div;
  logic [CFG_W:0]       trial;
  logic [CFG_W-1:0]     rem_step;
  logic [CFG_W-1:0]     rem_fix;
  logic [MW-1:0]        bucket_wide;

  logic [BW-1:0]        bucket_q;
  logic [AW-1:0]        base_q;
  logic [AW-1:0]        scan_addr;
  logic [BW-1:0]        wipe_row;

  logic [BUCKET_DEPTH-1:0] vrow;
  logic [KEY_W-1:0]        vdata;

  logic [IW-1:0]        iss_q;
  logic                 iss_end;
  logic                 pend_q;
  logic [SW-1:0]        cmp_idx_q;
  logic                 hit_q;
  logic [SW-1:0]        hit_idx_q;
  logic                 free_q;
  logic [SW-1:0]        free_idx_q;

  logic                 ins_place;
  logic                 rem_hit;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   count_next;

  // floor modulo: restoring remainder of the magnitude, then sign fix
  assign key_bits = key_value;
  assign key_abs  = key_bits[KEY_W-1] ? (~key_bits + KEY_W'(1)) : key_bits;
  assign eff_div  = (bucket_count == '0)   ? CFG_W'(1) :
                    (bucket_count > NB_CAP) ? NB_CAP : bucket_count;
  assign trial    = {rem_q, dvd_q[KEY_W-1]};
  assign rem_step = (trial >= {1'b0, div_q}) ? CFG_W'(trial - {1'b0, div_q})
                                             : trial[CFG_W-1:0];
  assign rem_fix  = (neg_q && (rem_q != '0)) ? (div_q - rem_q) : rem_q;
  assign bucket_wide = MW'(rem_fix);

  assign iss_end   = (iss_q == IW'(BUCKET_DEPTH));
  assign scan_addr = base_q + AW'(iss_q[SW-1:0]);

  assign stat.div_last  = (cnt_q == DIV_CNT_W'(KEY_W - 1));
  assign stat.scan_last = iss_end && pend_q;
  assign stat.wipe_last = (wipe_row == BW'(NUM_BUCKETS - 1));

  assign ins_place = (op_q == OP_INSERT) && !hit_q && free_q;
  assign rem_hit   = (op_q == OP_REMOVE) && hit_q;

  always_comb begin
    count_next = count_q;
    if (op_q == OP_CLEAR) begin
      count_next = '0;
    end else if (ins_place) begin
      count_next = count_q + COUNT_W'(1);
    end else if (rem_hit) begin
      count_next = count_q - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      key_q <= key_bits;
      neg_q <= key_bits[KEY_W-1];
      dvd_q <= key_abs;
      div_q <= eff_div;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd.div_step) begin
      dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
      rem_q <= rem_step;
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
    if (cmd.hash) begin
      bucket_q <= bucket_wide[BW-1:0];
    end
  end

  // bucket scan, one slot read per cycle, each slot compared in the cycle after its read
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      base_q <= AW'(bucket_q) * AW'(BUCKET_DEPTH);
      iss_q  <= '0;
      pend_q <= 1'b0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd.scan) begin
      if (!iss_end) begin
        iss_q     <= iss_q + IW'(1);
        pend_q    <= 1'b1;
        cmp_idx_q <= iss_q[SW-1:0];
      end else begin
        pend_q <= 1'b0;
      end
      if (pend_q) begin
        if (vrow[cmp_idx_q] && (vdata == key_q) && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cmp_idx_q;
        end
        if (!vrow[cmp_idx_q] && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wipe_row <= '0;
    end else if (cmd.wipe) begin
      wipe_row <= stat.wipe_last ? '0 : wipe_row + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wipe) begin
      valid_mem[wipe_row] <= '0;
    end else if (cmd.commit && ins_place) begin
      valid_mem[bucket_q] <= vrow | (BUCKET_DEPTH'(1) << free_idx_q);
    end else if (cmd.commit && rem_hit) begin
      valid_mem[bucket_q] <= vrow & ~(BUCKET_DEPTH'(1) << hit_idx_q);
    end
    vrow <= valid_mem[bucket_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && ins_place) begin
      slot_mem[base_q + AW'(free_idx_q)] <= key_q;
    end
    vdata <= slot_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        count_q <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      was_present   <= (op_q != OP_CLEAR) && hit_q;
      status        <= (op_q == OP_INSERT) && !hit_q && !free_q;
      element_count <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/hash_set_engine.sv @@
// top level of the hash set engine: register port, controller and datapath
//
//  channel   signals                                        handshake
//  --------  ---------------------------------------------  -------------------------
//  command   start, busy, operation, key_value              taken when start && !busy
//  result    done, was_present, status, element_count       one word per done pulse
//  config    psel, penable, pwrite, paddr, pwdata, prdata   written on access cycle
//
//  insert, remove and contains keep busy high through the bit-serial modulo
//  and the slot scan on the single read port of the slot memory; done follows
//  in the next cycle
//  clear keeps busy high while it wipes one valid row per cycle
//  after reset a clearing pass over all NUM_BUCKETS valid rows runs with busy high
//  results cannot be stalled; a new command may start in the cycle of done
`default_nettype none

module hash_set_engine #(
  parameter int NUM_BUCKETS  = hse_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_DEPTH = hse_pkg::BUCKET_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [hse_pkg::OP_W-1:0]            operation,
  input  logic signed [hse_pkg::KEY_W-1:0]    key_value,
  output logic                                done,
  output logic                                was_present,
  output logic                                status,
  output logic [hse_pkg::COUNT_W-1:0]         element_count,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hse_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [hse_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [hse_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import hse_pkg::*;

  logic [CFG_W-1:0]     bucket_count;
  logic [REG_IDX_W-1:0] reg_idx;
  dp_cmd_t              cmd;
  dp_stat_t             stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_BUCKET_COUNT)) begin
      bucket_count <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_BUCKET_COUNT) ? APB_DATA_W'(bucket_count) : '0;

  hse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  hse_datapath #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .key_value     (key_value),
    .bucket_count  (bucket_count),
    .done          (done),
    .was_present   (was_present),
    .status        (status),
    .element_count (element_count)
  );

endmodule

`default_nettype wire

@@ sv/hse_checker.sv @@
// port-level checks of the hash set engine and their binding
`default_nettype none

module hse_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic was_present,
  input logic status
);

  // an accepted command keeps the engine busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("engine not busy after a command was taken");

  // a result word only closes a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a preceding busy period");

  // no two result words back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // a full-bucket drop only happens for an absent value
  a_drop_absent: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> !was_present)
    else $error("drop flagged for a value already present");

endmodule

bind hash_set_engine hse_checker u_hse_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .was_present (was_present),
  .status      (status)
);

`default_nettype wire
